/* sv/tlsae_pkg.sv */
// Shared types and constants for the tile light shader with auto exposure.
package tlsae_pkg;

    localparam logic [2:0] OP_CELL       = 3'd0;
    localparam logic [2:0] OP_END_FRAME  = 3'd1;
    localparam logic [2:0] OP_DIRTY_SCR  = 3'd2;
    localparam logic [2:0] OP_RESET_EXPO = 3'd3;
    localparam logic [2:0] OP_DIRTY_CELL = 3'd4;

    localparam logic REG_DRIFT  = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    localparam logic [7:0]  GLYPH_SPACE = 8'h20;
    localparam logic [19:0] EXPO_MAX    = 20'hFFFFF;
    localparam logic [7:0]  DRIFT_RST   = 8'd40;
    localparam logic [9:0]  THRESH_RST  = 10'd4;
    localparam logic [1:0]  DIRTY_SET   = 2'd2;
    localparam int          LUM_HW      = 9;

    typedef struct packed {
        logic              seen;
        logic [1:0]        dirty;
        logic [14:0]       fin;
        logic [7:0]        glyph;
        logic [14:0]       colour;
        logic [LUM_HW-1:0] lum;
        logic [7:0]        b;
        logic [7:0]        g;
        logic [7:0]        r;
    } t_hist;

    localparam t_hist HIST_RST = '{seen: 1'b0, dirty: 2'd0, fin: 15'd0,
                                   glyph: GLYPH_SPACE, colour: 15'd0,
                                   lum: '0, b: 8'd0, g: 8'd0, r: 8'd0};

endpackage

/* sv/tlsae_hist_ram.sv */
// Per-cell history memory, one write port and one registered read port.
module tlsae_hist_ram #(
    parameter int DEPTH = 768,
    parameter int ADW   = 10
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADW-1:0]     i_waddr,
    input  tlsae_pkg::t_hist   i_wdata,
    input  logic               i_re,
    input  logic [ADW-1:0]     i_raddr,
    output tlsae_pkg::t_hist   o_rdata
);
    import tlsae_pkg::*;

    t_hist r_mem [DEPTH];
    t_hist r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/tlsae_div3.sv */
// Three-lane radix-4 restoring divider computing (num << 12) / den.
module tlsae_div3 #(
    parameter int AW = 21
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2:0][AW-1:0]    i_num,
    input  logic [15:0]           i_den,
    output logic                  o_done,
    output logic [2:0][AW+11:0]   o_quo
);
    localparam int QW    = AW + 12;
    localparam int NW    = QW + (QW % 2);
    localparam int STEPS = NW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [2:0][16:0]   r_rem, n_rem;
    logic [2:0][NW-1:0] r_q, n_q;
    logic [15:0]        r_den;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [16:0]        t;
    logic [NW-1:0]      q;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            t = r_rem[l];
            q = r_q[l];
            for (int s = 0; s < 2; s++) begin
                t = {t[15:0], q[NW-1]};
                q = {q[NW-2:0], 1'b0};
                if (t >= {1'b0, r_den}) begin
                    t = t - {1'b0, r_den};
                    q[0] = 1'b1;
                end
            end
            n_rem[l] = t;
            n_q[l]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            for (int l = 0; l < 3; l++) begin
                r_rem[l] <= '0;
                r_q[l]   <= NW'({i_num[l], 12'b0});
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_quo[l] = r_q[l][QW-1:0];
        end
    end
    assign o_done = r_done;
endmodule

/* sv/tile_light_shader_auto_exposure.sv */
// Top level: tile light shader with auto exposure, sequencer and registers.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------------------
//  request  | i_valid / o_ready             | i_operation .. i_recall
//  result   | o_valid / i_ready             | o_draw_* , o_exposure_out
//  config   | psel penable pwrite / pready  | paddr pwdata prdata
//
// A lit cell that needs shading passes through the shared radix-4 divider (three lanes,
// two quotient bits a cycle); an unlit cell that draws skips the divider, and other
// items skip shading. After reset the history memory is swept with o_ready low. One
// request is in flight at a time; a result waiting in the output register does not
// block the next request until it completes.
module tile_light_shader_auto_exposure #(
    parameter int GRID_COLS    = 32,
    parameter int GRID_ROWS    = 24,
    parameter int WINDOW_SHIFT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [4:0]  i_cell_col,
    input  logic [4:0]  i_cell_row,
    input  logic [15:0] i_light_level,
    input  logic [15:0] i_light_red,
    input  logic [15:0] i_light_green,
    input  logic [15:0] i_light_blue,
    input  logic [7:0]  i_glyph,
    input  logic [14:0] i_base_colour,
    input  logic [13:0] i_recall,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_draw_valid,
    output logic [4:0]  o_draw_col,
    output logic [4:0]  o_draw_row,
    output logic [7:0]  o_draw_glyph,
    output logic [14:0] o_draw_colour,
    output logic [19:0] o_exposure_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tlsae_pkg::*;

    localparam int WINDOW = 1 << WINDOW_SHIFT;
    localparam int WW     = WINDOW_SHIFT + 1;
    localparam int VW     = (WW > 12) ? WW : 12;
    localparam int PW     = 16 + VW;
    localparam int AW     = PW - 12;
    localparam int CELLS  = GRID_COLS * GRID_ROWS;
    localparam int ADW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SW     = VW - 7;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_READ  = 9'b000000100,
        S_EVAL  = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_SHADE = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [ADW-1:0] r_clr;
    logic [2:0]     r_op;
    logic [4:0]     r_col, r_row;
    logic [ADW-1:0] r_addr;
    logic           r_inside;
    logic [15:0]    r_lum;
    logic [2:0][15:0] r_light;
    logic [7:0]     r_glyph;
    logic [14:0]    r_colour;
    logic [13:0]    r_recall;

    logic [19:0]        r_low;
    logic signed [10:0] r_bal;
    logic [15:0]        r_peak;
    logic [1:0]         r_sdc;
    logic [7:0]         r_drift;
    logic [9:0]         r_thr;

    logic [WW-1:0]      r_w;
    logic [VW-1:0]      r_val;
    logic [15:0]        r_top;
    logic [2:0][VW-1:0] r_s;
    logic [14:0]        r_fin;

    logic        r_res_draw;
    logic [7:0]  r_res_glyph;
    logic [14:0] r_res_colour;

    logic        r_out_valid;
    logic        r_out_draw;
    logic [4:0]  r_out_col, r_out_row;
    logic [7:0]  r_out_glyph;
    logic [14:0] r_out_colour;
    logic [19:0] r_out_expo;

    t_hist          h, h_wr;
    logic           mem_we;
    logic [ADW-1:0] mem_waddr;

    logic               div_done;
    logic [2:0][AW-1:0] div_num;
    logic [2:0][AW+11:0] div_quo;

    logic [VW-1:0]  floor_v;
    logic           lum_lt, lum_gt;
    logic [20:0]    win_hi;
    logic [WW-1:0]  w;
    logic [VW-1:0]  val;
    logic [15:0]    top;
    logic           changed, upd, unlit_draw;
    logic [20:0]    up;
    logic [19:0]    low1;
    logic [2:0][PW-1:0]   prod;
    logic [2:0][VW+4:0]   cprod;
    logic [2:0][SW-1:0]   csh;
    logic [14:0]          fin;
    logic                 accept, cfg_wr, fin_new;

    function automatic logic [1:0] dec2(input logic [1:0] d);
        dec2 = (d != 2'd0) ? d - 2'd1 : 2'd0;
    endfunction

    tlsae_hist_ram #(.DEPTH(CELLS), .ADW(ADW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (h_wr),
        .i_re    (r_state == S_READ),
        .i_raddr (r_addr),
        .o_rdata (h)
    );

    tlsae_div3 #(.AW(AW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL),
        .i_num   (div_num),
        .i_den   (r_top),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign accept = i_valid && o_ready;
    assign cfg_wr = psel && penable && pwrite;
    assign o_ready = (r_state == S_IDLE);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_THRESH) ? 32'(r_thr) : 32'(r_drift);

    // window evaluation
    always_comb begin
        floor_v = VW'(r_recall[13:2]);
        win_hi  = 21'(r_low) + 21'(WINDOW);
        lum_lt  = 20'(r_lum) < r_low;
        lum_gt  = 21'(r_lum) > win_hi;
        if (lum_lt) begin
            w = '0;
        end else if (lum_gt) begin
            w = WW'(WINDOW);
        end else begin
            w = WW'(r_lum - r_low[15:0]);
        end
        val = (VW'(w) > floor_v) ? VW'(w) : floor_v;
        top = (r_light[0] > r_light[1]) ? r_light[0] : r_light[1];
        if (r_light[2] > top) begin
            top = r_light[2];
        end
        changed = (r_light[0][15:8] != h.r) || (r_light[1][15:8] != h.g) ||
                  (r_light[2][15:8] != h.b) || (LUM_HW'(w >> 8) != h.lum) ||
                  (r_colour != h.colour) || (r_glyph != h.glyph);
        upd = changed || (h.dirty != 2'd0) || (r_sdc != 2'd0);
        unlit_draw = (h.dirty != 2'd0) || (r_sdc != 2'd0) || h.seen;
        up = 21'(r_low) + 21'({r_bal[9:0], 1'b0});
        if (!r_bal[10] && (r_bal[9:0] > r_thr)) begin
            low1 = (up > 21'(EXPO_MAX)) ? EXPO_MAX : up[19:0];
        end else begin
            low1 = r_low;
        end
    end

    // products and shading
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i]    = PW'(r_light[i]) * PW'(r_val);
            div_num[i] = prod[i][PW-1:12];
            cprod[i]   = r_colour[5*i +: 5] * r_s[i];
            csh[i]     = cprod[i][VW+4:12];
            fin[5*i +: 5] = (csh[i] > SW'(31)) ? 5'd31 : csh[i][4:0];
        end
    end

    assign fin_new = (r_fin != h.fin);

    // history write port
    always_comb begin
        h_wr      = h;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        unique case (r_state)
            S_CLEAR: begin
                h_wr      = HIST_RST;
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            S_EVAL: begin
                if (r_inside && r_op == OP_DIRTY_CELL) begin
                    h_wr.dirty = DIRTY_SET;
                    mem_we     = 1'b1;
                end else if (r_inside && r_op == OP_CELL && r_lum != 16'd0 && !upd) begin
                    h_wr.seen  = 1'b1;
                    h_wr.dirty = dec2(h.dirty);
                    mem_we     = 1'b1;
                end
            end
            S_FIN: begin
                mem_we = 1'b1;
                if (r_lum != 16'd0) begin
                    h_wr.r      = r_light[0][15:8];
                    h_wr.g      = r_light[1][15:8];
                    h_wr.b      = r_light[2][15:8];
                    h_wr.lum    = LUM_HW'(r_w >> 8);
                    h_wr.colour = r_colour;
                    h_wr.glyph  = r_glyph;
                    h_wr.seen   = 1'b1;
                    if (fin_new) begin
                        h_wr.fin   = r_fin;
                        h_wr.dirty = dec2(DIRTY_SET);
                    end else begin
                        h_wr.dirty = dec2(h.dirty);
                    end
                end else begin
                    if (r_recall != 14'd0) begin
                        h_wr.fin    = r_fin;
                        h_wr.colour = r_fin;
                    end else begin
                        h_wr.fin    = 15'd0;
                        h_wr.colour = 15'd0;
                        h_wr.glyph  = GLYPH_SPACE;
                    end
                    h_wr.r    = 8'd0;
                    h_wr.g    = 8'd0;
                    h_wr.b    = 8'd0;
                    h_wr.lum  = '0;
                    h_wr.seen = 1'b0;
                    h_wr.dirty = h.seen ? dec2(DIRTY_SET) : dec2(h.dirty);
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == ADW'(CELLS - 1)) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ:  n_state = S_EVAL;
            S_EVAL: begin
                n_state = S_OUT;
                if (r_inside && r_op == OP_CELL) begin
                    if (r_lum != 16'd0 && upd) begin
                        n_state = S_MUL;
                    end else if (r_lum == 16'd0 && unlit_draw) begin
                        n_state = S_SHADE;
                    end
                end
            end
            S_MUL:   n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_SHADE;
            S_SHADE: n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_low       <= '0;
            r_bal       <= '0;
            r_peak      <= '0;
            r_sdc       <= '0;
            r_drift     <= DRIFT_RST;
            r_thr       <= THRESH_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (cfg_wr) begin
                if (paddr[2] == REG_DRIFT) begin
                    r_drift <= pwdata[7:0];
                end else begin
                    r_thr <= pwdata[9:0];
                end
            end
            if (r_state == S_EVAL) begin
                case (r_op)
                    OP_CELL: begin
                        if (r_inside && r_lum != 16'd0) begin
                            if (r_lum > r_peak) r_peak <= r_lum;
                            if (lum_lt && r_bal != -11'sd1024) r_bal <= r_bal - 11'sd1;
                            else if (!lum_lt && lum_gt && r_bal != 11'sd1023)
                                r_bal <= r_bal + 11'sd1;
                        end
                    end
                    OP_END_FRAME: begin
                        if (low1 != 20'd0 && 21'(r_peak) < 21'(low1) + 21'(WINDOW)) begin
                            r_low <= low1 - ((20'(r_drift) < low1) ? 20'(r_drift) : low1);
                        end else begin
                            r_low <= low1;
                        end
                        r_sdc  <= dec2(r_sdc);
                        r_bal  <= '0;
                        r_peak <= '0;
                    end
                    OP_DIRTY_SCR:  r_sdc <= DIRTY_SET;
                    OP_RESET_EXPO: r_low <= '0;
                    default: ;
                endcase
            end
            if (r_state == S_OUT && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_operation;
            r_col    <= i_cell_col;
            r_row    <= i_cell_row;
            r_addr   <= ADW'(int'(i_cell_row) * GRID_COLS + int'(i_cell_col));
            r_inside <= (7'(i_cell_col) < 7'(GRID_COLS)) && (7'(i_cell_row) < 7'(GRID_ROWS));
            r_lum    <= i_light_level;
            r_light  <= {i_light_blue, i_light_green, i_light_red};
            r_glyph  <= i_glyph;
            r_colour <= i_base_colour;
            r_recall <= i_recall;
        end
        if (r_state == S_EVAL) begin
            r_w          <= w;
            r_val        <= val;
            r_top        <= top;
            r_s          <= {floor_v, floor_v, floor_v};
            r_res_draw   <= 1'b0;
            r_res_glyph  <= 8'd0;
            r_res_colour <= 15'd0;
        end
        if (r_state == S_DIV && div_done) begin
            for (int i = 0; i < 3; i++) begin
                if (r_top == 16'd0 || VW'(div_quo[i]) < floor_v) begin
                    r_s[i] <= floor_v;
                end else begin
                    r_s[i] <= VW'(div_quo[i]);
                end
            end
        end
        if (r_state == S_SHADE) begin
            r_fin <= fin;
        end
        if (r_state == S_FIN) begin
            if (r_lum != 16'd0) begin
                r_res_draw <= fin_new || (h.dirty != 2'd0) || (r_sdc != 2'd0);
                r_res_glyph <= r_glyph;
            end else begin
                r_res_draw  <= 1'b1;
                r_res_glyph <= (r_recall != 14'd0) ? r_glyph : GLYPH_SPACE;
            end
            r_res_colour <= r_fin;
        end
        if (r_state == S_OUT && (!r_out_valid || i_ready)) begin
            r_out_draw   <= r_res_draw;
            r_out_col    <= r_res_draw ? r_col : 5'd0;
            r_out_row    <= r_res_draw ? r_row : 5'd0;
            r_out_glyph  <= r_res_draw ? r_res_glyph : 8'd0;
            r_out_colour <= r_res_draw ? r_res_colour : 15'd0;
            r_out_expo   <= r_low;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_draw_valid   = r_out_draw;
    assign o_draw_col     = r_out_col;
    assign o_draw_row     = r_out_row;
    assign o_draw_glyph   = r_out_glyph;
    assign o_draw_colour  = r_out_colour;
    assign o_exposure_out = r_out_expo;
endmodule

/* sv/tlsae_checker.sv */
// Port-level checks for the tile light shader, bound to the top level.
module tlsae_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_draw_valid,
    input logic [4:0]  o_draw_col,
    input logic [4:0]  o_draw_row,
    input logic [7:0]  o_draw_glyph,
    input logic [14:0] o_draw_colour,
    input logic [19:0] o_exposure_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_draw_colour) && $stable(o_exposure_out))
        else $error("result changed while stalled");

    a_nodraw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_draw_valid |->
        o_draw_col == 5'd0 && o_draw_row == 5'd0 && o_draw_glyph == 8'd0 &&
        o_draw_colour == 15'd0)
        else $error("idle draw fields not zero");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("reset did not idle the block");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken while busy");
endmodule

bind tile_light_shader_auto_exposure tlsae_checker u_tlsae_checker (.*);
